[design/itcf_pkg.sv]
// Shared types, constants and helpers for the IMU tilt complementary filter.
package itcf_pkg;

    localparam int ADC_BITS     = 10;
    localparam int ANGLE_BITS   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int CW           = 34;   // CORDIC x/y width
    localparam int ZW           = 20;   // CORDIC angle accumulator width
    localparam int PW           = 52;   // shared product register width
    localparam int SQW          = 38;   // sum of squares width
    localparam int SQRT_STEPS   = 19;
    localparam int CORDIC_STEPS = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACC_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAG     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MAG     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FT      = 3'd6;

    localparam logic [20:0] TWO_PI_Q16  = 21'd411775;
    localparam logic [20:0] PI_Q16      = 21'd205887;
    localparam logic [20:0] HALF_PI_Q16 = 21'd102944;
    localparam logic signed [CW-1:0] CORDIC_K_Q16 = 34'sd39797;
    localparam logic [24:0] GAIN_ONE    = 25'h100_0000;

    typedef struct packed {
        logic                  cmd;
        logic [ADC_BITS-1:0]   raw_x;
        logic [ADC_BITS-1:0]   raw_y;
        logic [ADC_BITS-1:0]   raw_z;
        logic [15:0]           dt;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] tilt_x_out;
        logic signed [15:0] tilt_y_out;
        logic               rejected;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NOP, OP_GY_INIT, OP_GY_MULDT, OP_CROT, OP_GY_RND, OP_GY_MULC, OP_GY_UPD,
        OP_AC_MUL, OP_AC_RND, OP_AC_SQ, OP_SQ_LOAD, OP_SQ_STEP, OP_CHECK,
        OP_AT_LOAD, OP_AT_NORM, OP_VROT, OP_AT_FIN, OP_MV_MUL, OP_MV_UPD, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic rej;
        logic norm_done;
        logic out_free;
    } t_status;

    function automatic logic [17:0] atan_lut(input logic [3:0] i);
        logic [17:0] v;
        case (i)
            4'd0:    v = 18'd51472;
            4'd1:    v = 18'd30386;
            4'd2:    v = 18'd16055;
            4'd3:    v = 18'd8150;
            4'd4:    v = 18'd4091;
            4'd5:    v = 18'd2047;
            4'd6:    v = 18'd1024;
            4'd7:    v = 18'd512;
            4'd8:    v = 18'd256;
            4'd9:    v = 18'd128;
            4'd10:   v = 18'd64;
            4'd11:   v = 18'd32;
            4'd12:   v = 18'd16;
            4'd13:   v = 18'd8;
            4'd14:   v = 18'd4;
            4'd15:   v = 18'd2;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANGLE_BITS-1:0] sat_angle(input logic signed [25:0] v);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        logic signed [ANGLE_BITS-1:0] r;
        hi = 26'sd32767;
        lo = -26'sd32768;
        if (v > hi) begin
            r = 16'sh7FFF;
        end else if (v < lo) begin
            r = 16'sh8000;
        end else begin
            r = v[ANGLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[design/itcf_datapath.sv]
// Datapath: configuration, angle state, shared multiplier, CORDIC, square root, output register.
module itcf_datapath import itcf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    logic [9:0]  r_acc_offset, r_gyro_offset;
    logic [15:0] r_acc_scale, r_gyro_scale, r_min_mag, r_max_mag, r_inv_ft;

    t_in_item                r_item;
    logic signed [15:0]      r_tilt_x, r_tilt_y;
    logic [PW-1:0]           r_prod;
    logic [34:0]             r_p;
    logic                    r_neg, r_cneg;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic signed [ZW-1:0]    r_cz;
    logic [18:0]             r_amag [3];
    logic                    r_aneg [3];
    logic [35:0]             r_sq   [3];
    logic [SQW-1:0]          r_sq_v, r_sq_r, r_sq_b;
    logic [24:0]             r_gain;
    logic                    r_rej;
    logic signed [15:0]      r_tgt_x, r_tgt_y;
    t_out_item               r_out;
    logic                    r_ovalid;

    // gyro operand selection
    logic [9:0]          raw_g;
    logic signed [10:0]  d_g;
    logic [10:0]         d_g_neg;
    logic [9:0]          dmag_g;
    logic signed [15:0]  ang_o;
    logic [16:0]         a_abs;
    logic [20:0]         a16, a_m, a_f, a_h;
    logic                c_neg;
    // accel operand selection
    logic [9:0]          raw_a;
    logic signed [10:0]  d_a;
    logic [10:0]         d_a_neg;
    logic [9:0]          dmag_a;
    // CORDIC
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic [CW-1:0]        xy_or;
    logic [16:0]          cmag;
    logic [16:0]          zc;
    logic [13:0]          zr;
    logic signed [15:0]   tgt_new;
    logic [1:0]           at_idx;
    // square root
    logic [SQW:0]         rb;
    logic                 sq_ge;
    logic [SQW-1:0]       sq_sum;
    // updates
    logic signed [15:0]   ang_sel, tgt_sel;
    logic signed [16:0]   e_v;
    logic [16:0]          e_mag;
    logic [24:0]          q_g;
    logic [18:0]          m_mv;
    logic signed [25:0]   ang26, q26, m26;
    logic [31:0]          gain_raw;
    logic [18:0]          mag;
    logic                 rej_now;

    always_comb begin
        raw_g   = i_cmd.sel[0] ? r_item.raw_y : r_item.raw_x;
        ang_o   = i_cmd.sel[0] ? r_tilt_x : r_tilt_y;
        d_g     = $signed({1'b0, raw_g}) - $signed({1'b0, r_gyro_offset});
        d_g_neg = -d_g;
        dmag_g  = d_g[10] ? d_g_neg[9:0] : d_g[9:0];

        // reduce |angle| (Q.12 -> Q.16) into [0, pi/2] and note the cosine sign
        a_abs = ang_o[15] ? 17'(-{ang_o[15], ang_o}) : {1'b0, ang_o};
        a16   = {a_abs, 4'b0};
        a_m   = (a16 >= TWO_PI_Q16) ? a16 - TWO_PI_Q16 : a16;
        a_f   = (a_m > PI_Q16) ? TWO_PI_Q16 - a_m : a_m;
        c_neg = a_f > HALF_PI_Q16;
        a_h   = c_neg ? PI_Q16 - a_f : a_f;

        case (i_cmd.sel)
            2'd0:    raw_a = r_item.raw_x;
            2'd1:    raw_a = r_item.raw_y;
            default: raw_a = r_item.raw_z;
        endcase
        d_a     = $signed({1'b0, raw_a}) - $signed({1'b0, r_acc_offset});
        d_a_neg = -d_a;
        dmag_a  = d_a[10] ? d_a_neg[9:0] : d_a[9:0];

        // vectoring pass 1 targets x, pass 2 targets y
        at_idx = {1'b0, i_cmd.sel[1]};

        xs    = r_cx >>> i_cmd.step;
        ys    = r_cy >>> i_cmd.step;
        at    = $signed({2'b0, atan_lut(i_cmd.step)});
        xy_or = r_cx | r_cy;

        if (r_cx < 0) begin
            cmag = 17'd0;
        end else if (r_cx > 34'sd65536) begin
            cmag = 17'd65536;
        end else begin
            cmag = r_cx[16:0];
        end

        if (r_cz < 0) begin
            zc = 17'd0;
        end else if (r_cz > $signed({1'b0, HALF_PI_Q16[18:0]})) begin
            zc = HALF_PI_Q16[16:0];
        end else begin
            zc = r_cz[16:0];
        end
        zr      = zc[16:4] + {12'd0, zc[3]};
        tgt_new = r_aneg[at_idx] ? -$signed({2'b0, zr}) : $signed({2'b0, zr});

        rb    = {1'b0, r_sq_r} + {1'b0, r_sq_b};
        sq_ge = {1'b0, r_sq_v} >= rb;
        case (i_cmd.sel)
            2'd0:    sq_sum = {2'b0, r_sq[0]} + {2'b0, r_sq[1]} + {2'b0, r_sq[2]};
            2'd1:    sq_sum = {2'b0, r_sq[1]} + {2'b0, r_sq[2]};
            default: sq_sum = {2'b0, r_sq[0]} + {2'b0, r_sq[2]};
        endcase

        ang_sel = i_cmd.sel[0] ? r_tilt_y : r_tilt_x;
        tgt_sel = i_cmd.sel[0] ? r_tgt_y : r_tgt_x;
        e_v     = {tgt_sel[15], tgt_sel} - {ang_sel[15], ang_sel};
        e_mag   = e_v[16] ? 17'(-e_v) : e_v[16:0];

        q_g   = {1'b0, r_prod[51:28]} + {24'd0, r_prod[27]};
        m_mv  = {1'b0, r_prod[41:24]} + {18'd0, r_prod[23]};
        ang26 = {{10{ang_sel[15]}}, ang_sel};
        q26   = r_neg ? -$signed({1'b0, q_g}) : $signed({1'b0, q_g});
        m26   = r_neg ? -$signed({7'b0, m_mv}) : $signed({7'b0, m_mv});

        gain_raw = r_item.dt * r_inv_ft;
        mag      = r_sq_r[18:0];
        rej_now  = ({3'b0, r_min_mag} > mag) || ({3'b0, r_max_mag} < mag);
    end

    // window decision is read by the controller in the check cycle itself
    assign o_status.rej       = rej_now;
    assign o_status.norm_done = (|xy_or[CW-1:28]) || (xy_or == '0);
    assign o_status.out_free  = !r_ovalid || i_out_ready;
    assign o_out_valid        = r_ovalid;
    assign o_out_data         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_offset  <= 10'd337;
            r_acc_scale   <= 16'd9637;
            r_gyro_offset <= 10'd252;
            r_gyro_scale  <= 16'd419;
            r_min_mag     <= 16'd2048;
            r_max_mag     <= 16'd3072;
            r_inv_ft      <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACC_OFFSET:  r_acc_offset  <= i_cfg_data[9:0];
                CFG_ACC_SCALE:   r_acc_scale   <= i_cfg_data;
                CFG_GYRO_OFFSET: r_gyro_offset <= i_cfg_data[9:0];
                CFG_GYRO_SCALE:  r_gyro_scale  <= i_cfg_data;
                CFG_MIN_MAG:     r_min_mag     <= i_cfg_data;
                CFG_MAX_MAG:     r_max_mag     <= i_cfg_data;
                CFG_INV_FT:      r_inv_ft      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_x <= '0;
            r_tilt_y <= '0;
            r_ovalid <= 1'b0;
            r_rej    <= 1'b0;
        end else begin
            if (i_load) begin
                r_item <= i_item;
                r_rej  <= 1'b0;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_ovalid         <= 1'b1;
                r_out.tilt_x_out <= r_tilt_x;
                r_out.tilt_y_out <= r_tilt_y;
                r_out.rejected   <= r_rej;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_GY_INIT: begin
                    r_prod <= PW'(dmag_g * r_gyro_scale);
                    r_neg  <= d_g[10];
                    r_cneg <= c_neg;
                    r_cx   <= CORDIC_K_Q16;
                    r_cy   <= '0;
                    r_cz   <= $signed({1'b0, a_h[18:0]});
                end
                OP_GY_MULDT: r_prod <= PW'(r_prod[25:0] * r_item.dt);
                OP_CROT: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - at;
                    end else begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + at;
                    end
                end
                OP_GY_RND:  r_p <= {1'b0, r_prod[41:8]} + {34'd0, r_prod[7]};
                OP_GY_MULC: begin
                    r_prod <= r_p * cmag;
                    r_neg  <= r_neg ^ r_cneg;
                end
                OP_GY_UPD: begin
                    if (i_cmd.sel[0]) begin
                        r_tilt_y <= sat_angle(ang26 + q26);
                    end else begin
                        r_tilt_x <= sat_angle(ang26 + q26);
                    end
                end
                OP_AC_MUL: begin
                    r_prod            <= PW'(dmag_a * r_acc_scale);
                    r_aneg[i_cmd.sel] <= d_a[10];
                end
                OP_AC_RND: r_amag[i_cmd.sel] <= {1'b0, r_prod[25:8]} + {18'd0, r_prod[7]};
                OP_AC_SQ:  r_sq[i_cmd.sel] <= 36'(r_amag[i_cmd.sel] * r_amag[i_cmd.sel]);
                OP_SQ_LOAD: begin
                    r_sq_v <= sq_sum;
                    r_sq_r <= '0;
                    r_sq_b <= SQW'(1) << 36;
                end
                OP_SQ_STEP: begin
                    if (sq_ge) begin
                        r_sq_v <= r_sq_v - rb[SQW-1:0];
                        r_sq_r <= (r_sq_r >> 1) + r_sq_b;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_b <= r_sq_b >> 2;
                end
                OP_CHECK: begin
                    r_rej  <= rej_now;
                    r_gain <= (gain_raw > {7'd0, GAIN_ONE}) ? GAIN_ONE : gain_raw[24:0];
                end
                OP_AT_LOAD: begin
                    r_cx <= $signed({15'd0, mag});
                    r_cy <= $signed({15'd0, r_amag[at_idx]});
                    r_cz <= '0;
                end
                OP_AT_NORM: begin
                    if (!o_status.norm_done) begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end
                end
                OP_VROT: begin
                    // no rotation left once y reaches zero
                    if (r_cy > 0) begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + at;
                    end else if (r_cy < 0) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - at;
                    end
                end
                OP_AT_FIN: begin
                    if (i_cmd.sel[1]) begin
                        r_tgt_y <= tgt_new;
                    end else begin
                        r_tgt_x <= tgt_new;
                    end
                end
                OP_MV_MUL: begin
                    r_prod <= PW'(e_mag * r_gain);
                    r_neg  <= e_v[16];
                end
                OP_MV_UPD: begin
                    if (i_cmd.sel[0]) begin
                        r_tilt_y <= sat_angle(ang26 + m26);
                    end else begin
                        r_tilt_x <= sat_angle(ang26 + m26);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[design/itcf_ctrl.sv]
// Controller: sequences the datapath through gyro and accel updates.
module itcf_ctrl import itcf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_G_INIT, S_G_MULDT, S_G_ROT, S_G_RND, S_G_MULC, S_G_UPD,
        S_A_MUL, S_A_RND, S_A_SQ, S_SQ_LOAD, S_SQ_STEP, S_CHECK,
        S_T_LOAD, S_T_NORM, S_T_ROT, S_T_FIN, S_M_MUL, S_M_UPD, S_EMIT
    } t_state;

    t_state     r_state;
    logic [1:0] r_sel;
    logic [4:0] r_step;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.sel  = r_sel;
        o_cmd.step = r_step[3:0];
        case (r_state)
            S_G_INIT:  o_cmd.op = OP_GY_INIT;
            S_G_MULDT: o_cmd.op = OP_GY_MULDT;
            S_G_ROT:   o_cmd.op = OP_CROT;
            S_G_RND:   o_cmd.op = OP_GY_RND;
            S_G_MULC:  o_cmd.op = OP_GY_MULC;
            S_G_UPD:   o_cmd.op = OP_GY_UPD;
            S_A_MUL:   o_cmd.op = OP_AC_MUL;
            S_A_RND:   o_cmd.op = OP_AC_RND;
            S_A_SQ:    o_cmd.op = OP_AC_SQ;
            S_SQ_LOAD: o_cmd.op = OP_SQ_LOAD;
            S_SQ_STEP: o_cmd.op = OP_SQ_STEP;
            S_CHECK:   o_cmd.op = OP_CHECK;
            S_T_LOAD:  o_cmd.op = OP_AT_LOAD;
            S_T_NORM:  o_cmd.op = OP_AT_NORM;
            S_T_ROT:   o_cmd.op = OP_VROT;
            S_T_FIN:   o_cmd.op = OP_AT_FIN;
            S_M_MUL:   o_cmd.op = OP_MV_MUL;
            S_M_UPD:   o_cmd.op = OP_MV_UPD;
            S_EMIT:    o_cmd.op = i_status.out_free ? OP_EMIT : OP_NOP;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_sel  <= '0;
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= i_in_cmd ? S_A_MUL : S_G_INIT;
                    end
                end
                S_G_INIT:  r_state <= S_G_MULDT;
                S_G_MULDT: begin
                    r_step  <= '0;
                    r_state <= S_G_ROT;
                end
                S_G_ROT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= S_G_RND;
                    end
                end
                S_G_RND:  r_state <= S_G_MULC;
                S_G_MULC: r_state <= S_G_UPD;
                S_G_UPD: begin
                    if (r_sel == 2'd0) begin
                        r_sel   <= 2'd1;
                        r_state <= S_G_INIT;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_A_MUL: r_state <= S_A_RND;
                S_A_RND: r_state <= S_A_SQ;
                S_A_SQ: begin
                    if (r_sel == 2'd2) begin
                        r_sel   <= 2'd0;
                        r_state <= S_SQ_LOAD;
                    end else begin
                        r_sel   <= r_sel + 2'd1;
                        r_state <= S_A_MUL;
                    end
                end
                S_SQ_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_SQ_STEP;
                end
                S_SQ_STEP: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(SQRT_STEPS - 1)) begin
                        r_state <= (r_sel == 2'd0) ? S_CHECK : S_T_LOAD;
                    end
                end
                S_CHECK: begin
                    if (i_status.rej) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_sel   <= 2'd1;
                        r_state <= S_SQ_LOAD;
                    end
                end
                S_T_LOAD: r_state <= S_T_NORM;
                S_T_NORM: begin
                    if (i_status.norm_done) begin
                        r_step  <= '0;
                        r_state <= S_T_ROT;
                    end
                end
                S_T_ROT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= S_T_FIN;
                    end
                end
                S_T_FIN: begin
                    if (r_sel == 2'd1) begin
                        r_sel   <= 2'd2;
                        r_state <= S_SQ_LOAD;
                    end else begin
                        r_sel   <= 2'd0;
                        r_state <= S_M_MUL;
                    end
                end
                S_M_MUL: r_state <= S_M_UPD;
                S_M_UPD: begin
                    if (r_sel == 2'd0) begin
                        r_sel   <= 2'd1;
                        r_state <= S_M_MUL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[design/imu_tilt_complementary_filter_top.sv]
// Top level of the two-axis IMU tilt complementary filter.
// One item is processed at a time. A gyro transaction runs, per axis, setup,
// a rate multiply, a 16-step CORDIC cosine rotation, rounding, a cosine
// multiply and the update, then loads the output register. An accel
// transaction scales the three axes, takes a 19-step square root for the
// magnitude and makes the window check; if rejected, it ends there. If
// accepted, each axis then gets a further 19-step square root, a
// normalizing shift and a 16-step CORDIC vectoring pass, and the two
// angle moves follow. All steps share one product register, one
// square-root unit and one CORDIC unit. The result sits in an output
// register, so the next transaction is taken while it waits.
// Configuration writes are always ready and belong where no transaction is
// in flight.
module imu_tilt_complementary_filter_top import itcf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    itcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itcf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_in_valid && o_in_ready),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[design/itcf_checker.sv]
// Port-level checker for the tilt filter top, with its bind.
module itcf_checker import itcf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // one transaction in flight: intake closes right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after accept");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind imu_tilt_complementary_filter_top itcf_checker u_itcf_checker (.*);
